FILE: hdl/audio_block_continuity_checker_unit_assert.svh
// assertion macros for the continuity checker
// used by the port checker module; no other dependencies
`ifndef AUDIO_BLOCK_CONTINUITY_CHECKER_UNIT_ASSERT_SVH
`define AUDIO_BLOCK_CONTINUITY_CHECKER_UNIT_ASSERT_SVH

// combinational property on every clock edge
`define ACBC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// property that holds in the cycle after a trigger
`define ACBC_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

FILE: hdl/acbc_pkg.sv
// shared types and constants for the audio block continuity checker
// no dependencies
package acbc_pkg;

   localparam int BUS_W       = 3;
   localparam int FRAMES_W    = 11;
   localparam int BYTES_W     = 16;
   localparam int SEQ_W       = 48;
   localparam int TIME_W      = 64;
   localparam int EXP_SEQ_W   = 49;
   localparam int VERDICT_W   = 2;
   localparam int RATE_W      = 17;
   localparam int CHAN_W      = 4;
   localparam int REQ_DATA_W  = 304;
   localparam int RSP_DATA_W  = 56;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int MUL_A_W     = 32;
   localparam int MUL_P_W     = 62;

   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

   localparam int DEF_BUS_COUNT        = 6;
   localparam int DEF_MAX_BLOCK_FRAMES = 1024;
   localparam int DEF_SEQUENCE_BITS    = 48;

   typedef enum logic [1:0] {
      REG_SAMPLE_RATE = 2'd0,
      REG_CHANNEL_COUNT = 2'd1,
      REG_ORIGIN_TIME = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      VERDICT_PLAIN = 2'd0,
      VERDICT_GAP = 2'd1,
      VERDICT_REJECT = 2'd2
   } verdict_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_A,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_REM,
      ST_DIV_B_GO,
      ST_DIV_B,
      ST_SUM,
      ST_FIN_A,
      ST_FIN_B,
      ST_OUT
   } state_type;

endpackage

FILE: hdl/audio_block_continuity_checker_unit.sv
// a block that reaches the time test takes two passes of the serial divider plus multiply and add steps
// before its result word; an early reject goes straight from the checks to the result word
// one word at a time: the next word is taken only once the result word is taken
// reset: synchronous, clears the per-bus sequence and frame totals and loads register defaults
// depends on acbc_pkg, acbc_div, acbc_mul
module audio_block_continuity_checker_unit #(
   parameter int BUS_COUNT        = acbc_pkg::DEF_BUS_COUNT,
   parameter int MAX_BLOCK_FRAMES = acbc_pkg::DEF_MAX_BLOCK_FRAMES,
   parameter int SEQUENCE_BITS    = acbc_pkg::DEF_SEQUENCE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // bus_index, frame_count, byte_count, block_sequence, block_time_ns,
   // gap_length, gap_start_sequence, gap_time_ns
   input  logic [acbc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // verdict, expected_sequence
   output logic [acbc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [acbc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [acbc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [acbc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int BIX_W = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
   localparam logic [63:0] SEQ_MAX = (64'd1 << SEQUENCE_BITS) - 64'd1;

   acbc_pkg::state_type state_ff, state_in;

   logic [acbc_pkg::RATE_W-1:0]    sr_ff;
   logic [acbc_pkg::CHAN_W-1:0]    cc_ff;
   logic [acbc_pkg::TIME_W-1:0]    origin_ff;

   logic [acbc_pkg::EXP_SEQ_W-1:0] nes_ff [BUS_COUNT];
   logic [acbc_pkg::TIME_W-1:0]    fsf_ff [BUS_COUNT];

   logic [acbc_pkg::BUS_W-1:0]     bus_ff;
   logic [acbc_pkg::FRAMES_W-1:0]  frames_ff;
   logic [acbc_pkg::BYTES_W-1:0]   bytes_ff;
   logic [acbc_pkg::SEQ_W-1:0]     seq_ff;
   logic [acbc_pkg::TIME_W-1:0]    btime_ff;
   logic [acbc_pkg::SEQ_W-1:0]     glen_ff;
   logic [acbc_pkg::SEQ_W-1:0]     gstart_ff;
   logic [acbc_pkg::TIME_W-1:0]    gtime_ff;

   logic [acbc_pkg::TIME_W-1:0]    secs_ff;
   logic [acbc_pkg::RATE_W-1:0]    rem_ff;
   logic [acbc_pkg::MUL_P_W-1:0]   prod_lo_ff;
   logic [acbc_pkg::MUL_P_W-1:0]   prod_hi_ff;
   logic [acbc_pkg::TIME_W-1:0]    big_ff;
   logic                           ok_ff;
   logic [acbc_pkg::TIME_W-1:0]    want_ff;
   logic [acbc_pkg::VERDICT_W-1:0] verdict_ff;

   logic                           in_range;
   logic [BIX_W-1:0]               bix;
   logic                           csr_wr;
   logic                           eval_ok;
   logic                           plain;
   logic [16:0]                    byte_want;
   logic [acbc_pkg::TIME_W:0]      fsf_sum;
   logic [acbc_pkg::EXP_SEQ_W-1:0] gap_end;
   logic [93:0]                    big_sum;
   logic [acbc_pkg::TIME_W-1:0]    delta;
   logic [acbc_pkg::TIME_W-1:0]    stamp;
   logic                           stamp_ok;
   logic [acbc_pkg::EXP_SEQ_W-1:0] exp_out;

   logic                           div_start;
   logic [acbc_pkg::TIME_W-1:0]    div_dividend;
   logic                           div_done;
   logic [acbc_pkg::TIME_W-1:0]    div_quot;
   logic [acbc_pkg::RATE_W-1:0]    div_rem;
   logic [acbc_pkg::MUL_A_W-1:0]   mul_a;
   logic [acbc_pkg::MUL_P_W-1:0]   mul_p;

   acbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (sr_ff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   acbc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_p (mul_p)
   );

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (acbc_pkg::reg_index_type'(csr_paddr[4:3]))
         acbc_pkg::REG_SAMPLE_RATE:   csr_prdata = acbc_pkg::CSR_DATA_W'(sr_ff);
         acbc_pkg::REG_CHANNEL_COUNT: csr_prdata = acbc_pkg::CSR_DATA_W'(cc_ff);
         acbc_pkg::REG_ORIGIN_TIME:   csr_prdata = origin_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   // checks that need no arithmetic unit
   assign in_range  = {1'b0, bus_ff} < (acbc_pkg::BUS_W + 1)'(BUS_COUNT);
   assign bix       = bus_ff[BIX_W-1:0];
   assign plain     = glen_ff == '0;
   assign byte_want = 17'(cc_ff) * 17'(frames_ff) * 17'd4;
   assign fsf_sum   = {1'b0, fsf_ff[bix]} + (acbc_pkg::TIME_W + 1)'(frames_ff);
   assign gap_end   = acbc_pkg::EXP_SEQ_W'(gstart_ff) + acbc_pkg::EXP_SEQ_W'(glen_ff);

   always_comb begin
      eval_ok = in_range && (frames_ff != '0)
         && (32'(frames_ff) <= 32'(MAX_BLOCK_FRAMES))
         && ({1'b0, bytes_ff} == byte_want)
         && (64'(seq_ff) <= SEQ_MAX)
         && (sr_ff != '0);
      if (plain) begin
         eval_ok = eval_ok && (acbc_pkg::EXP_SEQ_W'(seq_ff) == nes_ff[bix])
            && !fsf_sum[acbc_pkg::TIME_W];
      end else begin
         eval_ok = eval_ok && (acbc_pkg::EXP_SEQ_W'(gstart_ff) == nes_ff[bix])
            && (64'(gstart_ff) <= SEQ_MAX)
            && (gap_end == acbc_pkg::EXP_SEQ_W'(seq_ff));
      end
   end

   assign big_sum  = 94'(prod_lo_ff) + (94'(prod_hi_ff) << 32);
   assign delta    = big_ff + acbc_pkg::TIME_W'(secs_ff[29:0]);
   assign stamp    = plain ? btime_ff : gtime_ff;
   assign stamp_ok = (stamp == want_ff)
      || (({1'b0, want_ff} + 65'd1) == {1'b0, stamp})
      || (({1'b0, stamp} + 65'd1) == {1'b0, want_ff});
   assign exp_out  = in_range ? nes_ff[bix] : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         acbc_pkg::ST_IDLE:     if (req_tvalid) state_in = acbc_pkg::ST_EVAL;
         acbc_pkg::ST_EVAL:     state_in = eval_ok ? acbc_pkg::ST_DIV_A : acbc_pkg::ST_OUT;
         acbc_pkg::ST_DIV_A:    if (div_done) state_in = acbc_pkg::ST_MUL_LO;
         acbc_pkg::ST_MUL_LO:   state_in = acbc_pkg::ST_MUL_HI;
         acbc_pkg::ST_MUL_HI:   state_in = acbc_pkg::ST_MUL_REM;
         acbc_pkg::ST_MUL_REM:  state_in = acbc_pkg::ST_DIV_B_GO;
         acbc_pkg::ST_DIV_B_GO: state_in = acbc_pkg::ST_DIV_B;
         acbc_pkg::ST_DIV_B:    if (div_done) state_in = acbc_pkg::ST_SUM;
         acbc_pkg::ST_SUM:      state_in = acbc_pkg::ST_FIN_A;
         acbc_pkg::ST_FIN_A:    state_in = acbc_pkg::ST_FIN_B;
         acbc_pkg::ST_FIN_B:    state_in = acbc_pkg::ST_OUT;
         acbc_pkg::ST_OUT:      if (rsp_tready) state_in = acbc_pkg::ST_IDLE;
         default:               state_in = acbc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      div_start    = 1'b0;
      div_dividend = fsf_ff[bix];
      mul_a        = secs_ff[31:0];
      unique case (state_ff)
         acbc_pkg::ST_IDLE:     req_tready = 1'b1;
         acbc_pkg::ST_EVAL:     div_start = eval_ok;
         acbc_pkg::ST_MUL_HI:   mul_a = secs_ff[63:32];
         acbc_pkg::ST_MUL_REM:  mul_a = acbc_pkg::MUL_A_W'(rem_ff);
         acbc_pkg::ST_DIV_B_GO: begin
            div_start    = 1'b1;
            div_dividend = acbc_pkg::TIME_W'(mul_p);
         end
         acbc_pkg::ST_OUT:      rsp_tvalid = 1'b1;
         default:               ;
      endcase
   end

   assign rsp_tdata = acbc_pkg::RSP_DATA_W'({exp_out, verdict_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= acbc_pkg::ST_IDLE;
         sr_ff     <= 17'd48000;
         cc_ff     <= 4'd2;
         origin_ff <= '0;
         for (int i = 0; i < BUS_COUNT; i++) begin
            nes_ff[i] <= '0;
            fsf_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            case (acbc_pkg::reg_index_type'(csr_paddr[4:3]))
               acbc_pkg::REG_SAMPLE_RATE:   sr_ff <= csr_pwdata[acbc_pkg::RATE_W-1:0];
               acbc_pkg::REG_CHANNEL_COUNT: cc_ff <= csr_pwdata[acbc_pkg::CHAN_W-1:0];
               acbc_pkg::REG_ORIGIN_TIME:   origin_ff <= csr_pwdata;
               default:                     ;
            endcase
         end
         if (state_ff == acbc_pkg::ST_FIN_B && plain && ok_ff && stamp_ok) begin
            nes_ff[bix] <= acbc_pkg::EXP_SEQ_W'(seq_ff) + 1'b1;
            fsf_ff[bix] <= fsf_sum[acbc_pkg::TIME_W-1:0];
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         acbc_pkg::ST_IDLE: begin
            bus_ff    <= req_tdata[2:0];
            frames_ff <= req_tdata[13:3];
            bytes_ff  <= req_tdata[29:14];
            seq_ff    <= req_tdata[77:30];
            btime_ff  <= req_tdata[141:78];
            glen_ff   <= req_tdata[189:142];
            gstart_ff <= req_tdata[237:190];
            gtime_ff  <= req_tdata[301:238];
         end
         acbc_pkg::ST_EVAL:    verdict_ff <= acbc_pkg::VERDICT_REJECT;
         acbc_pkg::ST_DIV_A: begin
            secs_ff <= div_quot;
            rem_ff  <= div_rem;
         end
         acbc_pkg::ST_MUL_HI:  prod_lo_ff <= mul_p;
         acbc_pkg::ST_MUL_REM: prod_hi_ff <= mul_p;
         acbc_pkg::ST_DIV_B:   secs_ff <= div_quot;
         acbc_pkg::ST_SUM: begin
            big_ff <= big_sum[63:0];
            ok_ff  <= (big_sum[93:64] == '0) && (big_sum[63:0] <= ~origin_ff);
         end
         acbc_pkg::ST_FIN_A: begin
            ok_ff   <= ok_ff && (delta <= ~origin_ff);
            want_ff <= origin_ff + delta;
         end
         acbc_pkg::ST_FIN_B: begin
            if (ok_ff && stamp_ok) begin
               verdict_ff <= plain ? acbc_pkg::VERDICT_PLAIN : acbc_pkg::VERDICT_GAP;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: hdl/acbc_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on acbc_pkg
module acbc_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [acbc_pkg::TIME_W-1:0]          dividend,
   input  logic [acbc_pkg::RATE_W-1:0]          divisor,
   output logic                                 done,
   output logic [acbc_pkg::TIME_W-1:0]          quot,
   output logic [acbc_pkg::RATE_W-1:0]          rem
);

   localparam int CNT_W = $clog2(acbc_pkg::TIME_W);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [acbc_pkg::TIME_W-1:0]        q_ff, q_in;
   logic [acbc_pkg::RATE_W-1:0]        r_ff, r_in;
   logic [acbc_pkg::RATE_W:0]          r_sh;
   logic                               fits;

   always_comb begin
      r_sh    = {r_ff, q_ff[acbc_pkg::TIME_W-1]};
      fits    = r_sh >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         r_in    = '0;
      end else if (busy_ff) begin
         q_in   = {q_ff[acbc_pkg::TIME_W-2:0], fits};
         r_in   = fits ? acbc_pkg::RATE_W'(r_sh - {1'b0, divisor})
                       : r_sh[acbc_pkg::RATE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(acbc_pkg::TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

endmodule

FILE: hdl/acbc_mul.sv
// registered multiplier by one second in nanoseconds
// depends on acbc_pkg
module acbc_mul (
   input  logic                                 clock,
   input  logic [acbc_pkg::MUL_A_W-1:0]         mul_a,
   output logic [acbc_pkg::MUL_P_W-1:0]         mul_p
);

   logic [acbc_pkg::MUL_P_W-1:0] p_ff, p_in;

   assign p_in = acbc_pkg::MUL_P_W'(mul_a) * acbc_pkg::MUL_P_W'(acbc_pkg::NS_PER_SEC);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign mul_p = p_ff;

endmodule

FILE: hdl/acbc_checker.sv
// port-level checks for the continuity checker, bound to the top level
// depends on acbc_pkg and audio_block_continuity_checker_unit_assert.svh
`include "audio_block_continuity_checker_unit_assert.svh"

module acbc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [acbc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   `ACBC_ASSERT_ALWAYS(a_no_overlap, !(req_tready && rsp_tvalid), "ready while result pending")
   `ACBC_ASSERT_NEXT(a_busy_after_word, req_tvalid && req_tready, !req_tready, "took two words")
   `ACBC_ASSERT_NEXT(a_one_result, rsp_tvalid && rsp_tready, !rsp_tvalid, "result repeated")
   `ACBC_ASSERT_ALWAYS(a_verdict_code, !rsp_tvalid || (rsp_tdata[1:0] <= acbc_pkg::VERDICT_REJECT), "bad verdict")

endmodule

bind audio_block_continuity_checker_unit acbc_checker u_acbc_checker (.*);
